>>> sv/srig_pkg.sv
// Shared types and constants for the stream group reverser.
package srig_pkg;

  localparam int MAX_GROUP_DEF = 16;
  localparam int VAL_W         = 32;
  localparam int GS_W          = 5;
  localparam logic [GS_W-1:0] GS_RESET = GS_W'(1);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take;   // input item accepted this cycle
    logic issue;  // read one buffered value toward the output
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic emit;        // the item on the input would release the buffer
    logic last_issue;  // the current drain read is the final one
    logic advance;     // output register can load this cycle
  } sts_t;

endpackage

>>> sv/srig_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srig_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/srig_ctrl.sv
// Controller state machine: alternates between collecting items and draining a group.
module srig_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  srig_pkg::sts_t sts,
  output srig_pkg::cmd_t cmd
);

  import srig_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && sts.emit) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts.advance && sts.last_issue) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready  = 1'b0;
    cmd.take  = 1'b0;
    cmd.issue = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      ST_DRAIN: begin
        cmd.issue = sts.advance;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  a_no_take_while_draining: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN) |-> !cmd.take)
    else $error("item taken during drain");

  a_drain_follows_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && sts.emit) |=> (state == ST_DRAIN))
    else $error("releasing item did not start a drain");

  a_issue_only_in_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (state == ST_DRAIN) && sts.advance)
    else $error("read issued outside drain");

endmodule

>>> sv/srig_dp.sv
// Datapath: group size register, fill counter, group buffer and output register.
module srig_dp #(
  parameter int MAX_GROUP = srig_pkg::MAX_GROUP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [srig_pkg::GS_W-1:0]     cfg_wdata,
  input  logic signed [srig_pkg::VAL_W-1:0] item_value,
  input  logic                          final_item,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [srig_pkg::VAL_W-1:0] out_value,
  output logic                          run_end,
  output logic                          sequence_end,
  input  srig_pkg::cmd_t                cmd,
  output srig_pkg::sts_t                sts
);

  import srig_pkg::*;

  localparam int IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CNT_W = $clog2(MAX_GROUP + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_GROUP);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [GS_W-1:0]  group_size;
  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] drain_n;
  logic [IDX_W-1:0] k;
  logic             drain_rev;
  logic             drain_last;

  logic [CNT_W-1:0] eff_size;
  logic [CNT_W-1:0] fill_inc;
  logic             full;
  logic             room;
  logic [CNT_W-1:0] rev_addr;
  logic [IDX_W-1:0] raddr;
  logic [VAL_W-1:0] rdata;

  // Clamp the group size into 1..MAX_GROUP.
  always_comb begin
    if (group_size == '0) begin
      eff_size = CNT_ONE;
    end else if (32'(group_size) > 32'(MAX_GROUP)) begin
      eff_size = CNT_MAX;
    end else begin
      eff_size = CNT_W'(group_size);
    end
  end

  assign room     = (fill < CNT_MAX);
  assign fill_inc = room ? fill + CNT_ONE : fill;
  assign full     = (fill_inc >= eff_size);

  assign sts.emit       = full || final_item;
  assign sts.last_issue = (CNT_W'(k) == drain_n - CNT_ONE);
  assign sts.advance    = !out_valid || out_ready;

  assign rev_addr = drain_n - CNT_ONE - CNT_W'(k);
  assign raddr    = drain_rev ? rev_addr[IDX_W-1:0] : k;

  always_ff @(posedge clk) begin
    if (rst) begin
      group_size <= GS_RESET;
    end else if (cfg_we) begin
      group_size <= cfg_wdata;
    end
  end

  // Count buffered values; capture the drain plan when the buffer releases.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (cmd.take) begin
      fill <= sts.emit ? '0 : fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && sts.emit) begin
      drain_n    <= fill_inc;
      drain_rev  <= full;
      drain_last <= final_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.take) begin
      k <= '0;
    end else if (cmd.issue) begin
      k <= k + IDX_W'(1);
    end
  end

  // Output register: RAM read data plus registered flags, loaded together.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (sts.advance) begin
      out_valid <= cmd.issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      run_end      <= sts.last_issue;
      sequence_end <= sts.last_issue && drain_last;
    end
  end

  srig_ram #(
    .WIDTH(VAL_W),
    .DEPTH(MAX_GROUP)
  ) u_buf (
    .clk  (clk),
    .we   (cmd.take && room),
    .waddr(fill[IDX_W-1:0]),
    .wdata(VAL_W'(item_value)),
    .re   (cmd.issue),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign out_value = $signed(rdata);

  a_issue_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue |-> (CNT_W'(k) < drain_n))
    else $error("drain read past group end");

  a_last_read_marks_run_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.issue && sts.last_issue) |=> (out_valid && run_end))
    else $error("final read of a group not flagged");

  a_seq_end_implies_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && sequence_end) |-> run_end)
    else $error("sequence end without run end");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_MAX)
    else $error("fill count over buffer depth");

endmodule

>>> sv/stream_reverse_in_groups.sv
// Top level of the stream group reverser: controller plus datapath.
//
// Values stream in one item per handshake and are collected in a buffer of
// MAX_GROUP entries. Once group_size values are held (group_size 0 acts as 1,
// values above MAX_GROUP act as MAX_GROUP), the group leaves in reverse order;
// an item with final_item set releases whatever is held, reversed if it
// completes a group and in arrival order otherwise. run_end marks the last
// result of each release and sequence_end the last result of the sequence.
// While the block is collecting, an item is taken whenever in_valid is high.
// A release of n values then reads the buffer once per cycle through its
// single read port, holding while the output register cannot advance. The
// first read is issued once the drain has begun and the output register can
// advance, and its registered data is valid in the cycle after that. With
// out_ready high the results then follow back to back. Intake stays closed
// until the last read is issued. One input item can leave up to MAX_GROUP
// results. The output register holds a waiting result while the next items
// are collected. Write group_size only between sequences or while nothing is
// in flight. No clearing pass after reset; the buffer is never read before
// it is written.
module stream_reverse_in_groups #(
  parameter int MAX_GROUP = srig_pkg::MAX_GROUP_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [srig_pkg::GS_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [srig_pkg::VAL_W-1:0] item_value,
  input  logic                              final_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [srig_pkg::VAL_W-1:0] out_value,
  output logic                              run_end,
  output logic                              sequence_end
);

  import srig_pkg::*;

  cmd_t cmd;  // take an item, issue a buffer read
  sts_t sts;  // release pending, last read, output can advance

  // Sequence collect and drain phases.
  srig_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Hold the buffer, count the fill, and drive the output register.
  srig_dp #(
    .MAX_GROUP(MAX_GROUP)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .item_value  (item_value),
    .final_item  (final_item),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .out_value   (out_value),
    .run_end     (run_end),
    .sequence_end(sequence_end),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule
